// ===== rtl/rmq_pkg.sv =====
`timescale 1ns / 1ps
// rmq_pkg: shared constants and types for the rotation matrix to quaternion core
// no dependencies

package rmq_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DW            = 18;
  localparam int QB            = 18;
  localparam int LANES         = 3;
  localparam int DIFF_W        = DW + 1;

  localparam logic signed [DW-1:0] OUT_MAX = 18'sd131071;
  localparam logic [QB-1:0]        MAG_LIM = 18'd131072;

  typedef enum logic [1:0] {
    PICK_W = 2'd0,
    PICK_X = 2'd1,
    PICK_Y = 2'd2,
    PICK_Z = 2'd3
  } pick_e;

endpackage

// ===== rtl/rmq_mat_if.sv =====
`timescale 1ns / 1ps
// rmq_mat_if: matrix input channel with valid/ready handshake
// depends on rmq_pkg

interface rmq_mat_if;
  logic                            valid;
  logic                            ready;
  logic signed [rmq_pkg::DW-1:0]   row0_col0;
  logic signed [rmq_pkg::DW-1:0]   row0_col1;
  logic signed [rmq_pkg::DW-1:0]   row0_col2;
  logic signed [rmq_pkg::DW-1:0]   row1_col0;
  logic signed [rmq_pkg::DW-1:0]   row1_col1;
  logic signed [rmq_pkg::DW-1:0]   row1_col2;
  logic signed [rmq_pkg::DW-1:0]   row2_col0;
  logic signed [rmq_pkg::DW-1:0]   row2_col1;
  logic signed [rmq_pkg::DW-1:0]   row2_col2;

  modport source (
    output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
           row2_col0, row2_col1, row2_col2,
    input  ready
  );
  modport sink (
    input  valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
           row2_col0, row2_col1, row2_col2,
    output ready
  );
endinterface

// ===== rtl/rmq_quat_if.sv =====
`timescale 1ns / 1ps
// rmq_quat_if: quaternion result channel with valid/ready handshake
// depends on rmq_pkg

interface rmq_quat_if;
  logic                            valid;
  logic                            ready;
  logic signed [rmq_pkg::DW-1:0]   quat_x;
  logic signed [rmq_pkg::DW-1:0]   quat_y;
  logic signed [rmq_pkg::DW-1:0]   quat_z;
  logic signed [rmq_pkg::DW-1:0]   quat_w;
  logic [1:0]                      largest_pick;
  logic                            invalid;

  modport source (
    output valid, quat_x, quat_y, quat_z, quat_w, largest_pick, invalid,
    input  ready
  );
  modport sink (
    input  valid, quat_x, quat_y, quat_z, quat_w, largest_pick, invalid,
    output ready
  );
endinterface

// ===== rtl/rmq_sqrt_cell.sv =====
`timescale 1ns / 1ps
// rmq_sqrt_cell: one root bit of a pipelined integer square root
// no package dependencies

module rmq_sqrt_cell #(
  parameter int SW     = 18,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*SW-1:0]   op_i,
  input  logic [SW+1:0]     rem_i,
  input  logic [SW-1:0]     root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [2*SW-1:0]   op_o,
  output logic [SW+1:0]     rem_o,
  output logic [SW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [SW+3:0]   rem_sh;
  logic [SW+3:0]   trial;
  logic            ge;
  logic [SW+3:0]   rem_nx;
  logic [2*SW-1:0] op_d;
  logic [SW+1:0]   rem_d;
  logic [SW-1:0]   root_d;
  logic            valid_q;
  logic [2*SW-1:0] op_q;
  logic [SW+1:0]   rem_q;
  logic [SW-1:0]   root_q;
  logic [SIDE_W-1:0] side_q;

  always_comb begin
    rem_sh = {rem_i, op_i[2*SW-1 -: 2]};
    trial  = {2'b00, root_i, 2'b01};
    ge     = rem_sh >= trial;
    rem_nx = ge ? rem_sh - trial : rem_sh;
    rem_d  = rem_nx[SW+1:0];
    root_d = {root_i[SW-2:0], ge};
    op_d   = {op_i[2*SW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q   <= op_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/rmq_div_cell.sv =====
`timescale 1ns / 1ps
// rmq_div_cell: one quotient bit of three restoring division lanes sharing a divisor
// depends on rmq_pkg

module rmq_div_cell #(
  parameter int CW     = 56,
  parameter int DENW   = 19,
  parameter int BIT    = 0,
  parameter int SIDE_W = 1
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic [DENW-1:0]                         den_i,
  input  logic [rmq_pkg::LANES-1:0][CW-1:0]       rem_i,
  input  logic [rmq_pkg::LANES-1:0][rmq_pkg::QB-1:0] quo_i,
  input  logic [SIDE_W-1:0]                       side_i,
  output logic                                    valid_o,
  output logic [DENW-1:0]                         den_o,
  output logic [rmq_pkg::LANES-1:0][CW-1:0]       rem_o,
  output logic [rmq_pkg::LANES-1:0][rmq_pkg::QB-1:0] quo_o,
  output logic [SIDE_W-1:0]                       side_o
);

  logic [CW-1:0]                               trial;
  logic [rmq_pkg::LANES-1:0][CW-1:0]           rem_d;
  logic [rmq_pkg::LANES-1:0][rmq_pkg::QB-1:0]  quo_d;
  logic                                        valid_q;
  logic [DENW-1:0]                             den_q;
  logic [rmq_pkg::LANES-1:0][CW-1:0]           rem_q;
  logic [rmq_pkg::LANES-1:0][rmq_pkg::QB-1:0]  quo_q;
  logic [SIDE_W-1:0]                           side_q;

  always_comb begin
    trial = CW'(den_i) << BIT;
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      quo_d[l] = quo_i[l];
      if (rem_i[l] >= trial) begin
        rem_d[l]      = rem_i[l] - trial;
        quo_d[l][BIT] = 1'b1;
      end else begin
        rem_d[l]      = rem_i[l];
        quo_d[l][BIT] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q  <= den_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign den_o   = den_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/rotation_matrix_to_quaternion_core.sv =====
`timescale 1ns / 1ps
// rotation_matrix_to_quaternion_core: Shepperd matrix to quaternion conversion
// depends on rmq_pkg, rmq_mat_if, rmq_quat_if, rmq_sqrt_cell, rmq_div_cell
// SW = root width (18 at FRAC_BITS = 16)
// throughput: one matrix per cycle, set by the chain of root and quotient bit cells
// the whole chain holds while a finished result waits at the output register
// reset clears the valid bits of every stage; payload registers are not reset

module rotation_matrix_to_quaternion_core #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmq_mat_if.sink    mat_i,
  rmq_quat_if.source quat_o
);

  localparam int DW   = rmq_pkg::DW;
  localparam int QB   = rmq_pkg::QB;
  localparam int NL   = rmq_pkg::LANES;
  localparam int XW   = DW + 2;
  localparam int RW   = ((FRAC_BITS + 2 > XW) ? FRAC_BITS + 2 : XW) + 1;
  localparam int SW   = (RW - 1 + FRAC_BITS + 1) / 2;
  localparam int OW   = 2 * SW;
  localparam int DENW = SW + 1;
  localparam int MW   = ((rmq_pkg::DIFF_W + FRAC_BITS > SW) ?
                         rmq_pkg::DIFF_W + FRAC_BITS : SW) + 1;
  localparam int CW   = (MW > DENW + QB) ? MW : DENW + QB;
  localparam int EW   = SW + DW;

  typedef struct packed {
    logic [NL-1:0][rmq_pkg::DIFF_W-1:0] d;
    rmq_pkg::pick_e                     pick;
    logic                               inval;
  } s1_t;

  typedef struct packed {
    logic [DW-1:0]  bv;
    logic [NL-1:0]  neg;
    logic [NL-1:0]  ovf;
    rmq_pkg::pick_e pick;
    logic           inval;
  } s2_t;

  localparam int S1W = $bits(s1_t);
  localparam int S2W = $bits(s2_t);

  logic en;
  logic out_valid_q;

  assign en          = !out_valid_q || quat_o.ready;
  assign mat_i.ready = en;

  // front stage: diagonal sums, pick, radicand
  logic signed [XW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic signed [XW-1:0] tw, tx, ty, tz, big;
  logic signed [RW-1:0] rad;
  logic [OW-1:0]        op0_d;
  s1_t                  s1_d;
  logic signed [rmq_pkg::DIFF_W-1:0] d12m, d20m, d01m, d01p, d20p, d12p;

  always_comb begin
    a00 = XW'(mat_i.row0_col0);
    a01 = XW'(mat_i.row0_col1);
    a02 = XW'(mat_i.row0_col2);
    a10 = XW'(mat_i.row1_col0);
    a11 = XW'(mat_i.row1_col1);
    a12 = XW'(mat_i.row1_col2);
    a20 = XW'(mat_i.row2_col0);
    a21 = XW'(mat_i.row2_col1);
    a22 = XW'(mat_i.row2_col2);
    tw  = a00 + a11 + a22;
    tx  = a00 - a11 - a22;
    ty  = a11 - a00 - a22;
    tz  = a22 - a00 - a11;
    big       = tw;
    s1_d.pick = rmq_pkg::PICK_W;
    if (tx > big) begin
      big       = tx;
      s1_d.pick = rmq_pkg::PICK_X;
    end
    if (ty > big) begin
      big       = ty;
      s1_d.pick = rmq_pkg::PICK_Y;
    end
    if (tz > big) begin
      big       = tz;
      s1_d.pick = rmq_pkg::PICK_Z;
    end
    rad        = RW'(big) + (RW'(1) << FRAC_BITS);
    s1_d.inval = rad[RW-1] || (rad == '0);
    op0_d      = s1_d.inval ? '0 : (OW'(rad[RW-2:0]) << FRAC_BITS);
    d12m = rmq_pkg::DIFF_W'(a12 - a21);
    d20m = rmq_pkg::DIFF_W'(a20 - a02);
    d01m = rmq_pkg::DIFF_W'(a01 - a10);
    d01p = rmq_pkg::DIFF_W'(a01 + a10);
    d20p = rmq_pkg::DIFF_W'(a20 + a02);
    d12p = rmq_pkg::DIFF_W'(a12 + a21);
    unique case (s1_d.pick)
      rmq_pkg::PICK_W: s1_d.d = {d01m, d20m, d12m};
      rmq_pkg::PICK_X: s1_d.d = {d20p, d01p, d12m};
      rmq_pkg::PICK_Y: s1_d.d = {d12p, d01p, d20m};
      rmq_pkg::PICK_Z: s1_d.d = {d12p, d20p, d01m};
      default:         s1_d.d = {d01m, d20m, d12m};
    endcase
  end

  logic [SW:0]            sq_valid;
  logic [SW:0][OW-1:0]    sq_op;
  logic [SW:0][SW+1:0]    sq_rem;
  logic [SW:0][SW-1:0]    sq_root;
  logic [SW:0][S1W-1:0]   sq_side;
  logic                   front_valid_q;
  logic [OW-1:0]          front_op_q;
  s1_t                    front_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else if (en) begin
      front_valid_q <= mat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      front_op_q   <= op0_d;
      front_side_q <= s1_d;
    end
  end

  assign sq_valid[0] = front_valid_q;
  assign sq_op[0]    = front_op_q;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = front_side_q;

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    rmq_sqrt_cell #(
      .SW     (SW),
      .SIDE_W (S1W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[i]),
      .op_i    (sq_op[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .side_i  (sq_side[i]),
      .valid_o (sq_valid[i+1]),
      .op_o    (sq_op[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .side_o  (sq_side[i+1])
    );
  end

  // prep stage: divisor, dividends, overflow check, largest component
  s1_t                      s1_in;
  logic [SW-1:0]            s_root;
  logic [DENW-1:0]          den_d;
  logic [NL-1:0][CW-1:0]    num_d;
  logic [rmq_pkg::DIFF_W-1:0] mag;
  logic [EW-1:0]            bv_ext;
  s2_t                      s2_d;

  always_comb begin
    s1_in      = s1_t'(sq_side[SW]);
    s_root     = sq_root[SW];
    den_d      = {s_root, 1'b0};
    s2_d.pick  = s1_in.pick;
    s2_d.inval = s1_in.inval;
    bv_ext     = EW'(s_root >> 1);
    s2_d.bv    = (bv_ext > EW'(rmq_pkg::OUT_MAX)) ? rmq_pkg::OUT_MAX : bv_ext[DW-1:0];
    for (int l = 0; l < NL; l++) begin
      s2_d.neg[l] = s1_in.d[l][rmq_pkg::DIFF_W-1];
      mag         = s2_d.neg[l] ? -s1_in.d[l] : s1_in.d[l];
      num_d[l]    = (CW'(mag) << FRAC_BITS) + CW'(s_root);
      s2_d.ovf[l] = num_d[l] >= (CW'(den_d) << QB);
    end
  end

  logic [QB:0]                     dv_valid;
  logic [QB:0][DENW-1:0]           dv_den;
  logic [QB:0][NL-1:0][CW-1:0]     dv_rem;
  logic [QB:0][NL-1:0][QB-1:0]     dv_quo;
  logic [QB:0][S2W-1:0]            dv_side;
  logic                            prep_valid_q;
  logic [DENW-1:0]                 prep_den_q;
  logic [NL-1:0][CW-1:0]           prep_num_q;
  s2_t                             prep_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else if (en) begin
      prep_valid_q <= sq_valid[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_den_q  <= den_d;
      prep_num_q  <= num_d;
      prep_side_q <= s2_d;
    end
  end

  assign dv_valid[0] = prep_valid_q;
  assign dv_den[0]   = prep_den_q;
  assign dv_rem[0]   = prep_num_q;
  assign dv_quo[0]   = '0;
  assign dv_side[0]  = prep_side_q;

  for (genvar i = 0; i < QB; i++) begin : g_div
    rmq_div_cell #(
      .CW     (CW),
      .DENW   (DENW),
      .BIT    (QB - 1 - i),
      .SIDE_W (S2W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[i]),
      .den_i   (dv_den[i]),
      .rem_i   (dv_rem[i]),
      .quo_i   (dv_quo[i]),
      .side_i  (dv_side[i]),
      .valid_o (dv_valid[i+1]),
      .den_o   (dv_den[i+1]),
      .rem_o   (dv_rem[i+1]),
      .quo_o   (dv_quo[i+1]),
      .side_o  (dv_side[i+1])
    );
  end

  // output stage: clamp, sign, place components
  s2_t                      s2_in;
  logic [QB-1:0]            qmag;
  logic [NL-1:0][DW-1:0]    lane;
  logic signed [DW-1:0]     x_d, y_d, z_d, w_d;
  logic signed [DW-1:0]     x_q, y_q, z_q, w_q;
  rmq_pkg::pick_e           pick_q;
  logic                     inval_q;

  always_comb begin
    s2_in = s2_t'(dv_side[QB]);
    for (int l = 0; l < NL; l++) begin
      qmag = (s2_in.ovf[l] || dv_quo[QB][l] > rmq_pkg::MAG_LIM) ? rmq_pkg::MAG_LIM
                                                                : dv_quo[QB][l];
      if (s2_in.neg[l]) begin
        lane[l] = -qmag;
      end else if (qmag == rmq_pkg::MAG_LIM) begin
        lane[l] = rmq_pkg::OUT_MAX;
      end else begin
        lane[l] = qmag;
      end
    end
    unique case (s2_in.pick)
      rmq_pkg::PICK_W: begin
        w_d = s2_in.bv; x_d = lane[0]; y_d = lane[1]; z_d = lane[2];
      end
      rmq_pkg::PICK_X: begin
        w_d = lane[0]; x_d = s2_in.bv; y_d = lane[1]; z_d = lane[2];
      end
      rmq_pkg::PICK_Y: begin
        w_d = lane[0]; x_d = lane[1]; y_d = s2_in.bv; z_d = lane[2];
      end
      rmq_pkg::PICK_Z: begin
        w_d = lane[0]; x_d = lane[1]; y_d = lane[2]; z_d = s2_in.bv;
      end
      default: begin
        w_d = s2_in.bv; x_d = lane[0]; y_d = lane[1]; z_d = lane[2];
      end
    endcase
    if (s2_in.inval) begin
      w_d = '0; x_d = '0; y_d = '0; z_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      w_q     <= w_d;
      pick_q  <= s2_in.pick;
      inval_q <= s2_in.inval;
    end
  end

  assign quat_o.valid        = out_valid_q;
  assign quat_o.quat_x       = x_q;
  assign quat_o.quat_y       = y_q;
  assign quat_o.quat_z       = z_q;
  assign quat_o.quat_w       = w_q;
  assign quat_o.largest_pick = pick_q;
  assign quat_o.invalid      = inval_q;

endmodule

// ===== tb/tb_rotation_matrix_to_quaternion_core.sv =====
`timescale 1ns / 1ps
// tb_rotation_matrix_to_quaternion_core: random and directed matrices into the core,
// quaternion results checked in order against a built-in fixed point predictor
// depends on rmq_pkg, rmq_mat_if, rmq_quat_if and the core

typedef struct {
  logic signed [17:0] qx, qy, qz, qw;
  rmq_pkg::pick_e     pick;
  logic               invalid;
} quat_t;

class quat_scoreboard;
  quat_t pending[$];
  int    errors;

  function longint unsigned root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function logic signed [17:0] ratio(longint d, longint unsigned s);
    longint unsigned mag, q;
    mag = (d < 0) ? -d : d;
    q = ((mag << 16) + s) / (2 * s);
    if (q > 131072) q = 131072;
    if (d < 0) return (q >= 131072) ? -18'sd131072 : -$signed(q[17:0]);
    return (q > 131071) ? 18'sd131071 : q[17:0];
  endfunction

  function void note_matrix(logic signed [17:0] m[9]);
    longint a[9], t[4], big, rad, bv;
    longint unsigned s;
    quat_t e;
    int p;
    for (int i = 0; i < 9; i++) a[i] = m[i];
    t[0] = a[0] + a[4] + a[8];
    t[1] = a[0] - a[4] - a[8];
    t[2] = a[4] - a[0] - a[8];
    t[3] = a[8] - a[0] - a[4];
    p = 0;
    big = t[0];
    for (int i = 1; i < 4; i++) if (t[i] > big) begin
      big = t[i];
      p = i;
    end
    e.pick = rmq_pkg::pick_e'(p);
    e.qx = 0; e.qy = 0; e.qz = 0; e.qw = 0;
    rad = big + 65536;
    e.invalid = rad <= 0;
    if (!e.invalid) begin
      s = root_floor(rad << 16);
      bv = s >> 1;
      if (bv > 131071) bv = 131071;
      case (e.pick)
        rmq_pkg::PICK_W: begin
          e.qw = bv; e.qx = ratio(a[5] - a[7], s);
          e.qy = ratio(a[6] - a[2], s); e.qz = ratio(a[1] - a[3], s);
        end
        rmq_pkg::PICK_X: begin
          e.qx = bv; e.qw = ratio(a[5] - a[7], s);
          e.qy = ratio(a[1] + a[3], s); e.qz = ratio(a[6] + a[2], s);
        end
        rmq_pkg::PICK_Y: begin
          e.qy = bv; e.qw = ratio(a[6] - a[2], s);
          e.qx = ratio(a[1] + a[3], s); e.qz = ratio(a[5] + a[7], s);
        end
        default: begin
          e.qz = bv; e.qw = ratio(a[1] - a[3], s);
          e.qx = ratio(a[6] + a[2], s); e.qy = ratio(a[5] + a[7], s);
        end
      endcase
    end
    pending.push_back(e);
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_quat(quat_t g);
    quat_t e;
    if (pending.size() == 0) begin
      report("result with nothing pending");
      return;
    end
    e = pending.pop_front();
    if (g.qx !== e.qx) report($sformatf("x got %0d exp %0d", g.qx, e.qx));
    if (g.qy !== e.qy) report($sformatf("y got %0d exp %0d", g.qy, e.qy));
    if (g.qz !== e.qz) report($sformatf("z got %0d exp %0d", g.qz, e.qz));
    if (g.qw !== e.qw) report($sformatf("w got %0d exp %0d", g.qw, e.qw));
    if (g.pick !== e.pick) report($sformatf("pick got %0d exp %0d", g.pick, e.pick));
    if (g.invalid !== e.invalid) report($sformatf("invalid got %0b", g.invalid));
  endtask
endclass

module tb_rotation_matrix_to_quaternion_core;
  logic clk_i = 0;
  logic rst_ni = 0;
  rmq_mat_if  mat_if ();
  rmq_quat_if quat_if ();
  quat_scoreboard board = new();
  longint cycles = 0;
  logic signed [17:0] mat[9];
  bit sending_done = 0;

  rotation_matrix_to_quaternion_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .mat_i(mat_if.sink), .quat_o(quat_if.source)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_matrix();
    int g;
    g = gap_len();
    if (g != 0) begin
      mat_if.valid <= 0;
      repeat (g) @(negedge clk_i);
    end
    mat_if.valid <= 1;
    mat_if.row0_col0 <= mat[0]; mat_if.row0_col1 <= mat[1]; mat_if.row0_col2 <= mat[2];
    mat_if.row1_col0 <= mat[3]; mat_if.row1_col1 <= mat[4]; mat_if.row1_col2 <= mat[5];
    mat_if.row2_col0 <= mat[6]; mat_if.row2_col1 <= mat[7]; mat_if.row2_col2 <= mat[8];
    do @(posedge clk_i); while (!mat_if.ready);
    board.note_matrix(mat);
    @(negedge clk_i);
  endtask

  function automatic logic signed [17:0] rand_elem(int mode);
    case (mode)
      0: return 18'($urandom);
      1: return $signed(18'($urandom_range(0, 131072))) - 18'sd65536;
      default: return $signed(18'($urandom_range(0, 4096))) - 18'sd2048;
    endcase
  endfunction

  // full, mid or small range, or near-rotation: dominant diagonal signs, small noise
  task automatic make_random();
    int mode, kind;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 9; i++) mat[i] = rand_elem(mode == 3 ? 2 : mode);
    if (mode == 3) begin
      kind = $urandom_range(0, 3);
      mat[0] += (kind == 0 || kind == 1) ? 18'sd60000 : -18'sd60000;
      mat[4] += (kind == 0 || kind == 2) ? 18'sd60000 : -18'sd60000;
      mat[8] += (kind == 0 || kind == 3) ? 18'sd60000 : -18'sd60000;
    end
  endtask

  initial begin
    mat_if.valid = 0;
    for (int i = 0; i < 9; i++) mat[i] = 0;
    {mat_if.row0_col0, mat_if.row0_col1, mat_if.row0_col2} = '0;
    {mat_if.row1_col0, mat_if.row1_col1, mat_if.row1_col2} = '0;
    {mat_if.row2_col0, mat_if.row2_col1, mat_if.row2_col2} = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    // directed: identity, axis flips, extremes, ties
    for (int k = 0; k < 14; k++) begin
      for (int i = 0; i < 9; i++) mat[i] = 0;
      case (k)
        0: begin mat[0] = 65536; mat[4] = 65536; mat[8] = 65536; end
        1: begin mat[0] = 65536; mat[4] = -65536; mat[8] = -65536; end
        2: begin mat[0] = -65536; mat[4] = 65536; mat[8] = -65536; end
        3: begin mat[0] = -65536; mat[4] = -65536; mat[8] = 65536; end
        4: for (int i = 0; i < 9; i++) mat[i] = 18'sd131071;
        5: for (int i = 0; i < 9; i++) mat[i] = -18'sd131072;
        6: begin
          for (int i = 0; i < 9; i++) mat[i] = -18'sd131072;
          mat[0] = 0; mat[4] = 0; mat[8] = 0;
        end
        7: for (int i = 0; i < 9; i++) mat[i] = (i % 2) ? 18'sd131071 : -18'sd131072;
        8: begin mat[0] = -131072; mat[4] = -131072; mat[8] = -131072; end
        9: begin mat[1] = 131071; mat[3] = -131072; mat[5] = 131071; mat[7] = -131072; end
        10: begin mat[0] = 1; mat[4] = 1; mat[8] = 1; mat[2] = 131071; mat[6] = 131071; end
        11: begin mat[0] = -20000; mat[4] = -20000; mat[8] = -20000; end
        12: begin mat[0] = 0; mat[4] = -65536; mat[8] = 0; end
        default: begin mat[0] = 23170; mat[1] = -46341; mat[3] = 46341; mat[4] = 23170;
          mat[8] = 65536; end
      endcase
      send_matrix();
    end
    for (int n = 0; n < 1650; n++) begin
      make_random();
      send_matrix();
      if (n == 800) begin
        mat_if.valid <= 0;
        while (board.pending.size() != 0) @(negedge clk_i);
      end
    end
    mat_if.valid <= 0;
    sending_done = 1;
  end

  initial begin
    int g;
    quat_if.ready = 0;
    forever begin
      @(negedge clk_i);
      g = gap_len();
      if (g != 0) begin
        quat_if.ready <= 0;
        repeat (g) @(negedge clk_i);
      end
      quat_if.ready <= 1;
    end
  end

  always @(posedge clk_i) begin
    quat_t got;
    cycles <= cycles + 1;
    if (rst_ni && quat_if.valid && quat_if.ready) begin
      got.qx = quat_if.quat_x; got.qy = quat_if.quat_y;
      got.qz = quat_if.quat_z; got.qw = quat_if.quat_w;
      got.pick = rmq_pkg::pick_e'(quat_if.largest_pick);
      got.invalid = quat_if.invalid;
      board.check_quat(got);
    end
  end

  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    wait (cycles > 400000);
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
